// ===== design/animation_frame_timer_assert.svh =====
// Assertion macros for the animation frame timer.
// Each macro takes a label, an antecedent and a consequent.
`ifndef ANIMATION_FRAME_TIMER_ASSERT_SVH
`define ANIMATION_FRAME_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
`define AFT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("animation_frame_timer: same-cycle check failed");
`define AFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("animation_frame_timer: next-cycle check failed");
`else
`define AFT_ASSERT_SAME(label, ante, cons)
`define AFT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/aft_pkg.sv =====
package aft_pkg;

    // frame duration table
    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // fixed point layout of the animation time
    localparam int FRAC_BITS = 8;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = TIME_W - FRAC_BITS;

    typedef enum logic [1:0] {
        CFG_LOOP_ENABLE = 2'd0,
        CFG_SEQ_LENGTH  = 2'd1,
        CFG_FIRST_FRAME = 2'd2,
        CFG_FRAME_COUNT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADJUST,
        ST_PRIME,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

// ===== design/animation_frame_timer.sv =====
// A load, held or terminal item goes from idle straight to finish; a tick item
// steps through add, wrap or clamp and table prime, then walks one frame
// duration per cycle through the shared adder, and then finishes.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset (synchronous, active low) clears time, flag,
// frame and configuration; the duration table is not cleared.
`include "animation_frame_timer_assert.svh"

module animation_frame_timer import aft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic signed [15:0] i_time_step,
    input  logic        i_hold,
    input  logic [5:0]  i_slot,
    input  logic [15:0] i_slot_ticks,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_frame_index,
    output logic        o_terminal,
    output logic signed [31:0] o_anim_time,
    output logic        o_frame_changed
);

    // configuration registers
    logic        r_loop;
    logic [15:0] r_seq_len;
    logic [5:0]  r_first;
    logic [6:0]  r_frame_count;

    // sequencer and state
    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_pos;
    logic                r_term;
    logic [6:0]          r_frame;
    logic [6:0]          r_old_frame;
    logic [15:0]         r_step;
    logic [SUM_W-1:0]    r_sum;
    logic [6:0]          r_i;

    // frame duration memory
    logic [15:0]         r_tbl [TABLE_DEPTH];
    logic [15:0]         r_rd_data;
    logic [TBL_AW-1:0]   rd_addr;
    logic [6:0]          rd_off;
    logic                tbl_we;

    // output register
    logic                r_out_valid;
    logic [6:0]          r_out_frame;
    logic                r_out_term;
    logic [TIME_W-1:0]   r_out_time;
    logic                r_out_changed;

    // shared adder
    logic [TIME_W-1:0]   alu_a, alu_b, alu_y;
    logic                alu_sub;

    logic                in_acc;
    logic                out_free;
    logic                is_load;
    logic                pos_under, pos_over;
    logic [TIME_W-1:0]   clamp_hi;
    logic [TIME_W-1:0]   adj_time;
    logic                adj_term;
    logic [SUM_W-1:0]    walk_sum;
    logic                walk_end, walk_hit;
    logic                tick_neg;
    logic [SUM_W-1:0]    elapsed;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_load  = (t_cmd'(i_cmd) == CMD_LOAD);
    assign tbl_we   = in_acc && is_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop        <= 1'b0;
            r_seq_len     <= 16'd1;
            r_first       <= 6'd0;
            r_frame_count <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOOP_ENABLE: r_loop        <= i_cfg_wdata[0];
                CFG_SEQ_LENGTH:  r_seq_len     <= i_cfg_wdata;
                CFG_FIRST_FRAME: r_first       <= i_cfg_wdata[5:0];
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // shared adder
    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // wrap or clamp decision on the raw sum
    assign pos_under = r_pos[TIME_W-1];
    assign pos_over  = !r_pos[TIME_W-1] &&
                       (r_pos[TIME_W-1:FRAC_BITS] >= SUM_W'(r_seq_len));
    assign clamp_hi  = {SUM_W'(SUM_W'(r_seq_len) - SUM_W'(1)), FRAC_BITS'(0)};

    always_comb begin
        adj_time = r_pos;
        adj_term = 1'b0;
        if (pos_under || pos_over) begin
            if (r_loop) begin
                adj_time = alu_y;
            end else begin
                adj_term = 1'b1;
                adj_time = pos_under ? '0 : clamp_hi;
            end
        end
    end

    // whole ticks truncate toward zero: a time above minus one tick is tick 0
    assign tick_neg = r_time[TIME_W-1] &&
                      !((&r_time[TIME_W-1:FRAC_BITS]) && (|r_time[FRAC_BITS-1:0]));
    assign elapsed  = r_time[TIME_W-1] ? '0 : r_time[TIME_W-1:FRAC_BITS];

    // frame walk compare
    assign walk_sum = alu_y[SUM_W-1:0];
    assign walk_end = (r_i == r_frame_count);
    assign walk_hit = (elapsed < walk_sum);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_load || i_hold || r_term) n_state = ST_FINISH;
                    else                             n_state = ST_ADD;
                end
            end
            ST_ADD:    n_state = ST_ADJUST;
            ST_ADJUST: n_state = ST_PRIME;
            ST_PRIME:  n_state = tick_neg ? ST_FINISH : ST_WALK;
            ST_WALK:   n_state = (walk_end || walk_hit) ? ST_FINISH : ST_WALK;
            ST_FINISH: n_state = out_free ? ST_IDLE : ST_FINISH;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: adder operands, read address, input stall
    always_comb begin
        alu_a      = r_time;
        alu_b      = '0;
        alu_sub    = 1'b0;
        rd_off     = 7'd0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_ADD: begin
                alu_a = r_time;
                alu_b = TIME_W'(signed'(r_step));
            end
            ST_ADJUST: begin
                alu_a   = r_pos;
                alu_b   = {SUM_W'(r_seq_len), FRAC_BITS'(0)};
                alu_sub = !pos_under;
            end
            ST_PRIME: rd_off = 7'd0;
            ST_WALK: begin
                alu_a  = TIME_W'(r_sum);
                alu_b  = TIME_W'(r_rd_data);
                rd_off = 7'(r_i + 7'd1);
            end
            ST_FINISH: ;
            default: ;
        endcase
    end

    assign rd_addr = TBL_AW'(TBL_AW'(r_first) + TBL_AW'(rd_off));

    // duration table: write on load beats, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_tbl[TBL_AW'(i_slot)] <= i_slot_ticks;
        r_rd_data <= r_tbl[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_time  <= '0;
            r_term  <= 1'b0;
            r_frame <= 7'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ADJUST) begin
                r_time <= adj_time;
                if (adj_term) r_term <= 1'b1;
            end
            if (r_state == ST_PRIME && tick_neg) r_frame <= 7'd0;
            if (r_state == ST_WALK && (walk_end || walk_hit)) r_frame <= r_i;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_frame <= r_frame;
            r_step      <= i_time_step;
        end
        if (r_state == ST_ADD) r_pos <= alu_y;
        if (r_state == ST_PRIME) begin
            r_sum <= '0;
            r_i   <= 7'd0;
        end
        if (r_state == ST_WALK) begin
            r_sum <= walk_sum;
            r_i   <= 7'(r_i + 7'd1);
        end
    end

    // output register: load on finish, drop on accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_frame   <= r_frame;
            r_out_term    <= r_term;
            r_out_time    <= r_time;
            r_out_changed <= (r_frame != r_old_frame);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_index   = r_out_frame;
    assign o_terminal      = r_out_term;
    assign o_anim_time     = signed'(r_out_time);
    assign o_frame_changed = r_out_changed;

    // checks
    `AFT_ASSERT_NEXT(a_term_sticky, r_term, r_term)
    `AFT_ASSERT_SAME(a_walk_bound, r_state == ST_WALK, r_i <= r_frame_count)
    `AFT_ASSERT_NEXT(a_accept_busy, in_acc, r_state != ST_IDLE)
    `AFT_ASSERT_SAME(a_out_from_finish, $rose(r_out_valid), $past(r_state == ST_FINISH))

endmodule
